FILE: src/wfr_pkg.sv
`timescale 1ns / 1ps

package wfr_pkg;

  localparam int FrameBytes = 32;
  localparam int IdxW       = $clog2(FrameBytes);
  localparam int CntW       = $clog2(FrameBytes + 1);
  localparam int EvqDepth   = 4;
  localparam int EvqPtrW    = $clog2(EvqDepth);

  localparam logic [7:0] KFend    = 8'hC0;
  localparam logic [7:0] KFesc    = 8'hDB;
  localparam logic [7:0] KTfend   = 8'hDC;
  localparam logic [7:0] KTfesc   = 8'hDD;
  localparam logic [7:0] KCrcSeed = 8'hDE;
  localparam logic [7:0] KCrcXor  = 8'h18;
  localparam logic [7:0] KCrcTop  = 8'h80;
  localparam logic [7:0] KLow7    = 8'h7F;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LINE   = 3'd1,
    ST_ESCAPE = 3'd2,
    ST_CMDBIT = 3'd3,
    ST_LENGTH = 3'd4,
    ST_CRC    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_CMD,
    PH_LEN,
    PH_DATA
  } phase_e;

  typedef enum logic {
    BK_FETCH,
    BK_PLAY
  } back_state_e;

  // One event handed from the deframer to playback
  typedef struct packed {
    status_e         status;
    logic [6:0]      command;
    logic [CntW-1:0] count;
  } evt_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [7:0]      data;
  } memwr_t;

  // Maxim CRC-8, reflected, LSB first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] v;
    c = crc;
    v = b;
    for (int i = 0; i < 8; i++) begin
      if ((v[0] ^ c[0]) == 1'b1) begin
        c = ((c ^ KCrcXor) >> 1) | KCrcTop;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    return c;
  endfunction

endpackage

FILE: src/wfr_evq.sv
`timescale 1ns / 1ps

module wfr_evq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wfr_pkg::evt_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wfr_pkg::evt_t head_o
);
  import wfr_pkg::*;

  evt_t                 mem_q [EvqDepth];
  logic [EvqPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [EvqPtrW:0]     cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (EvqPtrW+1)'(EvqDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: src/wfr_front.sv
`timescale 1ns / 1ps

module wfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [6:0]      own_address_i,
  input  logic            valid_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            line_error_i,
  output logic            ready_o,
  input  logic            evq_full_i,
  output logic            evq_push_o,
  output wfr_pkg::evt_t   evq_data_o,
  output wfr_pkg::memwr_t mem_wr_o,
  input  logic            pkt_done_i
);
  import wfr_pkg::*;

  localparam logic [7:0] CrcAfterFend = crc_feed(KCrcSeed, KFend);

  phase_e          phase_q, phase_d;
  logic [7:0]      prior_q, prior_d;
  logic [6:0]      cmd_q, cmd_d;
  logic [CntW-1:0] exp_q, exp_d;
  logic [7:0]      crc_q, crc_d;
  logic [CntW-1:0] wp_q, wp_d;
  logic            busy_q, busy_d;

  logic            acc;
  logic [7:0]      v;
  logic [7:0]      crc_in;
  logic [7:0]      crc_nx;
  logic            addr_byte;

  // held off while the event queue is full or while a good packet's data sits in the store awaiting playback
  assign ready_o = !evq_full_i && !busy_q;
  assign acc     = valid_i && ready_o;

  // byte after undoing an escape pair
  assign v = (prior_q != KFesc)     ? rx_byte_i :
             (rx_byte_i == KTfesc)  ? KFesc :
             (rx_byte_i == KTfend)  ? KFend : rx_byte_i;

  assign addr_byte = (phase_q == PH_ADDR) && v[7];
  assign crc_in    = addr_byte ? (v & KLow7) : v;
  assign crc_nx    = crc_feed(crc_q, crc_in);

  always_comb begin
    phase_d    = phase_q;
    prior_d    = prior_q;
    cmd_d      = cmd_q;
    exp_d      = exp_q;
    crc_d      = crc_q;
    wp_d       = wp_q;
    busy_d     = busy_q;
    evq_push_o = 1'b0;
    evq_data_o = '{status: ST_OK, command: '0, count: '0};
    mem_wr_o   = '{en: 1'b0, addr: wp_q[IdxW-1:0], data: '0};

    if (pkt_done_i) begin
      busy_d = 1'b0;
    end

    if (acc) begin
      if (line_error_i) begin
        evq_push_o        = 1'b1;
        evq_data_o.status = ST_LINE;
        phase_d           = PH_IDLE;
      end else if (rx_byte_i == KFend) begin
        prior_d = rx_byte_i;
        crc_d   = CrcAfterFend;
        phase_d = PH_ADDR;
      end else if (phase_q != PH_IDLE) begin
        prior_d = rx_byte_i;

        if (prior_q == KFesc && rx_byte_i != KTfesc && rx_byte_i != KTfend) begin
          evq_push_o        = 1'b1;
          evq_data_o.status = ST_ESCAPE;
          phase_d           = PH_IDLE;
        end else if (prior_q != KFesc && rx_byte_i == KFesc) begin
          // first half of an escape pair: wait for the second
        end else begin
          case (phase_q)
            PH_ADDR, PH_CMD: begin
              if (addr_byte) begin
                if (v[6:0] == '0 || v[6:0] == own_address_i) begin
                  crc_d   = crc_nx;
                  phase_d = PH_CMD;
                end else begin
                  phase_d = PH_IDLE;
                end
              end else if (v[7]) begin
                evq_push_o        = 1'b1;
                evq_data_o.status = ST_CMDBIT;
                phase_d           = PH_IDLE;
              end else begin
                cmd_d   = v[6:0];
                crc_d   = crc_nx;
                phase_d = PH_LEN;
              end
            end
            PH_LEN: begin
              if (v > 8'(FrameBytes)) begin
                evq_push_o        = 1'b1;
                evq_data_o.status = ST_LENGTH;
                phase_d           = PH_IDLE;
              end else begin
                exp_d   = v[CntW-1:0];
                crc_d   = crc_nx;
                wp_d    = '0;
                phase_d = PH_DATA;
              end
            end
            PH_DATA: begin
              if (wp_q < exp_q) begin
                mem_wr_o.en   = 1'b1;
                mem_wr_o.data = v;
                wp_d          = wp_q + 1'b1;
                crc_d         = crc_nx;
              end else if (v != crc_q) begin
                evq_push_o        = 1'b1;
                evq_data_o.status = ST_CRC;
                phase_d           = PH_IDLE;
              end else begin
                evq_push_o = 1'b1;
                evq_data_o = '{status: ST_OK, command: cmd_q, count: exp_q};
                busy_d     = 1'b1;
                phase_d    = PH_IDLE;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prior_q <= '0;
      cmd_q   <= '0;
      exp_q   <= '0;
      crc_q   <= '0;
      wp_q    <= '0;
      busy_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      prior_q <= prior_d;
      cmd_q   <= cmd_d;
      exp_q   <= exp_d;
      crc_q   <= crc_d;
      wp_q    <= wp_d;
      busy_q  <= busy_d;
    end
  end

endmodule

FILE: src/wfr_back.sv
`timescale 1ns / 1ps

module wfr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wfr_pkg::memwr_t   mem_wr_i,
  input  logic              evq_empty_i,
  input  wfr_pkg::evt_t     evq_head_i,
  output logic              evq_pop_o,
  output logic              pkt_done_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [2:0]        status_o,
  output logic [6:0]        command_o,
  output logic [5:0]        byte_count_o,
  output logic [7:0]        payload_byte_o,
  output logic [4:0]        byte_index_o,
  output logic              last_o
);
  import wfr_pkg::*;

  logic [7:0]      store_q [FrameBytes];

  back_state_e     state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            ovalid_q, ovalid_d;
  status_e         ostatus_q;
  logic [6:0]      ocmd_q;
  logic [CntW-1:0] ocount_q;
  logic [7:0]      opay_q;
  logic [IdxW-1:0] oidx_q;
  logic            olast_q;

  logic            room;
  logic            ld;
  logic            ld_zero;
  logic [IdxW-1:0] rd_addr;
  logic            ld_last;
  logic [CntW-1:0] ld_count;
  logic            single;

  assign room   = !ovalid_q || pop_i;
  assign single = (evq_head_i.status != ST_OK) || (evq_head_i.count == '0);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    ld         = 1'b0;
    ld_zero    = 1'b0;
    ld_last    = 1'b0;
    ld_count   = evq_head_i.count;
    rd_addr    = idx_q[IdxW-1:0];
    evq_pop_o  = 1'b0;
    pkt_done_o = 1'b0;

    case (state_q)
      BK_FETCH: begin
        if (room && !evq_empty_i) begin
          ld        = 1'b1;
          rd_addr   = '0;
          if (single) begin
            ld_zero    = 1'b1;
            ld_last    = 1'b1;
            evq_pop_o  = 1'b1;
            pkt_done_o = (evq_head_i.status == ST_OK);
          end else begin
            ld_last = (evq_head_i.count == CntW'(1));
            idx_d   = CntW'(1);
            if (ld_last) begin
              evq_pop_o  = 1'b1;
              pkt_done_o = 1'b1;
            end else begin
              state_d = BK_PLAY;
            end
          end
        end
      end
      BK_PLAY: begin
        if (room) begin
          ld      = 1'b1;
          ld_last = (idx_q + 1'b1 == evq_head_i.count);
          idx_d   = idx_q + 1'b1;
          if (ld_last) begin
            evq_pop_o  = 1'b1;
            pkt_done_o = 1'b1;
            state_d    = BK_FETCH;
          end
        end
      end
      default: begin
        state_d = BK_FETCH;
      end
    endcase

    ovalid_d = ld ? 1'b1 : (pop_i ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_FETCH;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      store_q[mem_wr_i.addr] <= mem_wr_i.data;
    end
  end

  // result register, payload read straight out of the store
  always_ff @(posedge clk_i) begin
    if (ld) begin
      ostatus_q <= evq_head_i.status;
      ocmd_q    <= evq_head_i.command;
      ocount_q  <= ld_count;
      opay_q    <= ld_zero ? '0 : store_q[rd_addr];
      oidx_q    <= ld_zero ? '0 : rd_addr;
      olast_q   <= ld_last;
    end
  end

  assign empty_o        = !ovalid_q;
  assign status_o       = ostatus_q;
  assign command_o      = ocmd_q;
  assign byte_count_o   = 6'(ocount_q);
  assign payload_byte_o = opay_q;
  assign byte_index_o   = 5'(oidx_q);
  assign last_o         = olast_q;

endmodule

FILE: src/wake_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Wake packet receiver with CRC-8 check. Received UART bytes (with the UART's
// line-error flag) are pushed in one per transaction; the deframer strips FEND,
// undoes FESC escape pairs, filters on the station address (broadcast 0 or
// own_address) and checks the Maxim CRC-8 (seed 0xDE). A good packet comes out
// as one result per data byte (status 0, command, byte_count, payload_byte,
// byte_index, last on the final one), an empty packet as a single result; each
// error comes out as one result with its status code and last set. Timing: the
// deframer takes one byte per cycle whenever full is low. After the CRC byte of
// a good packet, full stays high until the last of its data bytes has been
// loaded into the result register, because the single payload store is read
// back one entry per cycle while results are popped and must not be refilled
// meanwhile. Errors only pass through a four-deep event queue and hold the input
// off only once that queue fills. There is no clearing pass after reset.
module wake_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input, queue style
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        line_error_i,
  // results, queue style
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  status_o,
  output logic [6:0]  command_o,
  output logic [5:0]  byte_count_o,
  output logic [7:0]  payload_byte_o,
  output logic [4:0]  byte_index_o,
  output logic        last_o,
  // APB-style config port; own_address at byte address 0
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wfr_pkg::*;

  logic       own_addr_sel;
  logic [6:0] own_address_q;
  logic       front_ready;
  logic       evq_full, evq_empty, evq_push, evq_pop;
  evt_t       evq_data, evq_head;
  memwr_t     mem_wr;
  logic       pkt_done;

  // config register: word select is paddr[2], byte offset ignored
  assign own_addr_sel = (paddr[2] == 1'b0);
  assign pready       = 1'b1;
  assign prdata       = own_addr_sel ? {25'd0, own_address_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= '0;
    end else if (psel && penable && pwrite && own_addr_sel) begin
      own_address_q <= pwdata[6:0];
    end
  end

  assign full_o = !front_ready;

  // front: deframing, escape, address filter, CRC
  wfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .own_address_i (own_address_q),
    .valid_i       (push_i),
    .rx_byte_i     (rx_byte_i),
    .line_error_i  (line_error_i),
    .ready_o       (front_ready),
    .evq_full_i    (evq_full),
    .evq_push_o    (evq_push),
    .evq_data_o    (evq_data),
    .mem_wr_o      (mem_wr),
    .pkt_done_i    (pkt_done)
  );

  // event queue between deframer and playback
  wfr_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evq_push),
    .data_i  (evq_data),
    .full_o  (evq_full),
    .pop_i   (evq_pop),
    .empty_o (evq_empty),
    .head_o  (evq_head)
  );

  // back: payload store and result playback
  wfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mem_wr_i       (mem_wr),
    .evq_empty_i    (evq_empty),
    .evq_head_i     (evq_head),
    .evq_pop_o      (evq_pop),
    .pkt_done_o     (pkt_done),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .status_o       (status_o),
    .command_o      (command_o),
    .byte_count_o   (byte_count_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .last_o         (last_o)
  );

endmodule
